### sv/pns_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pns_pkg
// Shared types, constants and arithmetic helpers of the 3D gradient noise
// sample unit.
// ----------------------------------------------------------------------------
package pns_pkg;

  localparam int FRAC_BITS = 24;
  localparam int PERM_SIZE = 256;
  localparam int PERM_AW   = $clog2(PERM_SIZE);
  localparam int DIV_W     = 2 * FRAC_BITS;
  localparam int DIV_LAT   = DIV_W;
  localparam int CFG_W     = 32;
  localparam int CLAMP_W   = FRAC_BITS + 1;

  // Request kinds
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] CFG_OFFSET_X = 3'd0;
  localparam logic [2:0] CFG_OFFSET_Y = 3'd1;
  localparam logic [2:0] CFG_OFFSET_Z = 3'd2;
  localparam logic [2:0] CFG_Y_STEP   = 3'd3;
  localparam logic [2:0] CFG_Y_CLAMP  = 3'd4;

  // Fixed-point constants
  localparam logic [63:0] EPS_FIX =
    ((64'd1 << FRAC_BITS) * 64'd109951 + (64'd1 << 39)) >> 40;
  localparam logic signed [25:0] ONE_FIX     = 26'sd1 <<< FRAC_BITS;
  localparam logic signed [29:0] TEN_ONE     = 30'sd10 <<< FRAC_BITS;
  localparam logic signed [29:0] FIFTEEN_ONE = 30'sd15 <<< FRAC_BITS;
  localparam logic signed [29:0] OUT_MAX     = 30'sd33554431;
  localparam logic signed [29:0] OUT_MIN     = -30'sd33554432;

  // Per-request data that travels alongside the quantization divider
  typedef struct packed {
    logic                 typ;
    logic [7:0]           pidx;
    logic [7:0]           pval;
    logic [7:0]           ci;
    logic [7:0]           cj;
    logic [7:0]           ck;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fh;
    logic [FRAC_BITS-1:0] fz;
  } side_t;

  // Dot product of a corner offset with one of the 16 gradient directions
  function automatic logic signed [26:0] dot_grad(input logic [3:0] hv,
                                                  input logic signed [25:0] x,
                                                  input logic signed [25:0] y,
                                                  input logic signed [25:0] z);
    logic signed [26:0] sx;
    logic signed [26:0] sy;
    logic signed [26:0] sz;
    logic signed [26:0] r;
    sx = 27'(x);
    sy = 27'(y);
    sz = 27'(z);
    unique case (hv)
      4'd0:    r = sx + sy;
      4'd1:    r = sy - sx;
      4'd2:    r = sx - sy;
      4'd3:    r = -sx - sy;
      4'd4:    r = sx + sz;
      4'd5:    r = sz - sx;
      4'd6:    r = sx - sz;
      4'd7:    r = -sx - sz;
      4'd8:    r = sy + sz;
      4'd9:    r = sz - sy;
      4'd10:   r = sy - sz;
      4'd11:   r = -sy - sz;
      4'd12:   r = sx + sy;
      4'd13:   r = sz - sy;
      4'd14:   r = sy - sx;
      default: r = -sy - sz;
    endcase
    return r;
  endfunction

  // a + floor(w * (b - a))
  function automatic logic signed [29:0] lerp_fix(input logic signed [25:0] w,
                                                  input logic signed [29:0] a,
                                                  input logic signed [29:0] b);
    logic signed [30:0] diff;
    logic signed [56:0] prod;
    diff = 31'(b) - 31'(a);
    prod = 57'(w) * 57'(diff);
    return a + 30'(prod >>> FRAC_BITS);
  endfunction

endpackage

### sv/pns_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pns_div
// Fully pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pns_div import pns_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [DIV_W-1:0] dividend,
  input  logic [CFG_W-1:0] divisor,
  output logic [DIV_W-1:0] quotient
);

  logic [CFG_W-1:0] rem [DIV_LAT];
  logic [DIV_W-1:0] wq  [DIV_LAT];

  genvar s;
  for (s = 0; s < DIV_LAT; s++) begin : g_stage
    logic [CFG_W-1:0] rem_prev;
    logic [DIV_W-1:0] w_prev;
    logic [CFG_W:0]   trial;
    logic [CFG_W:0]   diff;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_prev = '0;
      assign w_prev   = dividend;
    end else begin : g_next
      assign rem_prev = rem[s-1];
      assign w_prev   = wq[s-1];
    end

    // Shift in the next dividend bit and try the subtract
    assign trial = {rem_prev, w_prev[DIV_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = trial >= {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
        wq[s]  <= {w_prev[DIV_W-2:0], ge};
      end
    end
  end

  assign quotient = wq[DIV_LAT-1];

endmodule

### sv/pns_perm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pns_perm_ram
// One copy of the permutation table: one write port, two registered reads.
// ----------------------------------------------------------------------------
module pns_perm_ram import pns_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic               we,
  input  logic [PERM_AW-1:0] waddr,
  input  logic [7:0]         wdata,
  input  logic [PERM_AW-1:0] raddr0,
  input  logic [PERM_AW-1:0] raddr1,
  output logic [7:0]         rdata0,
  output logic [7:0]         rdata1
);

  logic [7:0] mem [PERM_SIZE];

  // Store one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read both ports, hold on stall
  always_ff @(posedge clk) begin
    if (en) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

### sv/perlin_noise_sample_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perlin_noise_sample_unit
// Improved 3D gradient noise with a loadable permutation table.
// ----------------------------------------------------------------------------
// The unit takes one request per clock while the output is not stalled. A
// sample request yields one noise value; a table write yields nothing and
// takes effect in request order. The y quantization divider, a 48-stage
// restoring pipeline (one quotient bit per stage), sits between the input
// register and seven further stages of table lookups, fade polynomials,
// gradient dot products and the three lerp levels.
// The permutation table is held in seven copies (one for the first hash
// level, two for the second, four for the corner hashes) so that all reads
// of one sample happen in flight; a write updates each copy as it passes
// that copy's read stage. A stalled output freezes the whole pipeline.
module perlin_noise_sample_unit import pns_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [2:0]                cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      req_type,
  input  logic [7:0]                perm_index,
  input  logic [7:0]                perm_value,
  input  logic signed [49:0]        x_coord,
  input  logic signed [49:0]        y_coord,
  input  logic signed [49:0]        z_coord,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [25:0]        noise_value
);

  // Configuration registers
  logic [CFG_W-1:0]          offset_x;
  logic [CFG_W-1:0]          offset_y;
  logic [CFG_W-1:0]          offset_z;
  logic [CFG_W-1:0]          y_step;
  logic signed [CLAMP_W-1:0] y_clamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
      offset_z <= '0;
      y_step   <= '0;
      y_clamp  <= -(CLAMP_W'(1) <<< FRAC_BITS);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_OFFSET_X: offset_x <= cfg_data;
        CFG_OFFSET_Y: offset_y <= cfg_data;
        CFG_OFFSET_Z: offset_z <= cfg_data;
        CFG_Y_STEP:   y_step   <= cfg_data;
        CFG_Y_CLAMP:  y_clamp  <= $signed(cfg_data[CLAMP_W-1:0]);
        default:      ;
      endcase
    end
  end

  // Global advance: the pipeline moves unless the output is held
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: add offsets, split into cell and fraction
  logic             v1;
  side_t            sd1;
  logic [CFG_W-1:0] dx, dy, dz;

  assign dx = x_coord[CFG_W-1:0] + offset_x;
  assign dy = y_coord[CFG_W-1:0] + offset_y;
  assign dz = z_coord[CFG_W-1:0] + offset_z;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd1.typ  <= req_type;
      sd1.pidx <= perm_index;
      sd1.pval <= perm_value;
      sd1.ci   <= dx[CFG_W-1:FRAC_BITS];
      sd1.cj   <= dy[CFG_W-1:FRAC_BITS];
      sd1.ck   <= dz[CFG_W-1:FRAC_BITS];
      sd1.fx   <= dx[FRAC_BITS-1:0];
      sd1.fh   <= dy[FRAC_BITS-1:0];
      sd1.fz   <= dz[FRAC_BITS-1:0];
    end
  end

  // Quantization divide: clamp the y fraction, then n * 2^F / y_step
  logic [FRAC_BITS-1:0] n1;
  logic [DIV_W-1:0]     t2;

  assign n1 = (!y_clamp[CLAMP_W-1] && (y_clamp[FRAC_BITS-1:0] < sd1.fh))
            ? y_clamp[FRAC_BITS-1:0] : sd1.fh;

  pns_div u_div (
    .clk      (clk),
    .en       (en),
    .dividend ({n1, {FRAC_BITS{1'b0}}}),
    .divisor  (y_step),
    .quotient (t2)
  );

  // Carry request data alongside the divider
  side_t              sp [DIV_LAT];
  logic [DIV_LAT-1:0] vp;

  always_ff @(posedge clk) begin
    if (rst) vp <= '0;
    else if (en) vp <= {vp[DIV_LAT-2:0], v1};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp[0] <= sd1;
      for (int s = 1; s < DIV_LAT; s++) begin
        sp[s] <= sp[s-1];
      end
    end
  end

  logic  v2;
  side_t sd2;
  assign v2  = vp[DIV_LAT-1];
  assign sd2 = sp[DIV_LAT-1];

  // Stage 3: quotient rounding, first hash level, fade step one
  logic                v3;
  side_t               sd3;
  logic [FRAC_BITS:0]  q3;
  logic [DIV_W:0]      t_eps;
  logic [7:0]          ha3, hb3;

  assign t_eps = {1'b0, t2} + (DIV_W + 1)'(EPS_FIX);

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd3 <= sd2;
      q3  <= t_eps[DIV_W:FRAC_BITS];
    end
  end

  pns_perm_ram u_ram_l1 (
    .clk    (clk),
    .en     (en),
    .we     (en && v2 && sd2.typ == REQ_WRITE),
    .waddr  (sd2.pidx),
    .wdata  (sd2.pval),
    .raddr0 (sd2.ci),
    .raddr1 (sd2.ci + 8'd1),
    .rdata0 (ha3),
    .rdata1 (hb3)
  );

  // Stage 4: quotient times step, second hash level, fade step two
  logic                v4;
  side_t               sd4;
  logic [56:0]         prod4;
  logic [7:0]          hc4, hd4, he4, hf4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd4   <= sd3;
      prod4 <= 57'(q3) * 57'(y_step);
    end
  end

  pns_perm_ram u_ram_l2a (
    .clk    (clk),
    .en     (en),
    .we     (en && v3 && sd3.typ == REQ_WRITE),
    .waddr  (sd3.pidx),
    .wdata  (sd3.pval),
    .raddr0 (ha3 + sd3.cj),
    .raddr1 (ha3 + sd3.cj + 8'd1),
    .rdata0 (hc4),
    .rdata1 (hd4)
  );

  pns_perm_ram u_ram_l2b (
    .clk    (clk),
    .en     (en),
    .we     (en && v3 && sd3.typ == REQ_WRITE),
    .waddr  (sd3.pidx),
    .wdata  (sd3.pval),
    .raddr0 (hb3 + sd3.cj),
    .raddr1 (hb3 + sd3.cj + 8'd1),
    .rdata0 (he4),
    .rdata1 (hf4)
  );

  // Stage 5: quantized y fraction, corner hashes, fade step three
  logic               v5;
  side_t              sd5;
  logic signed [25:0] fy5;
  logic [57:0]        fy_full;
  logic [7:0]         hg5 [8];

  assign fy_full = {34'b0, sd4.fh} - {1'b0, prod4};

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd5 <= sd4;
      fy5 <= (y_step != '0) ? $signed(fy_full[25:0]) : $signed({2'b0, sd4.fh});
    end
  end

  // Corner order: 000, 001 / 100, 101 / 010, 011 / 110, 111
  pns_perm_ram u_ram_l3c (
    .clk (clk), .en (en),
    .we (en && v4 && sd4.typ == REQ_WRITE), .waddr (sd4.pidx), .wdata (sd4.pval),
    .raddr0 (hc4 + sd4.ck), .raddr1 (hc4 + sd4.ck + 8'd1),
    .rdata0 (hg5[0]), .rdata1 (hg5[4])
  );

  pns_perm_ram u_ram_l3e (
    .clk (clk), .en (en),
    .we (en && v4 && sd4.typ == REQ_WRITE), .waddr (sd4.pidx), .wdata (sd4.pval),
    .raddr0 (he4 + sd4.ck), .raddr1 (he4 + sd4.ck + 8'd1),
    .rdata0 (hg5[1]), .rdata1 (hg5[5])
  );

  pns_perm_ram u_ram_l3d (
    .clk (clk), .en (en),
    .we (en && v4 && sd4.typ == REQ_WRITE), .waddr (sd4.pidx), .wdata (sd4.pval),
    .raddr0 (hd4 + sd4.ck), .raddr1 (hd4 + sd4.ck + 8'd1),
    .rdata0 (hg5[2]), .rdata1 (hg5[6])
  );

  pns_perm_ram u_ram_l3f (
    .clk (clk), .en (en),
    .we (en && v4 && sd4.typ == REQ_WRITE), .waddr (sd4.pidx), .wdata (sd4.pval),
    .raddr0 (hf4 + sd4.ck), .raddr1 (hf4 + sd4.ck + 8'd1),
    .rdata0 (hg5[3]), .rdata1 (hg5[7])
  );

  // Fade 6t^5 - 15t^4 + 10t^3 per axis over stages 3 to 5
  logic signed [25:0] w5 [3];

  genvar c;
  for (c = 0; c < 3; c++) begin : g_fade
    logic [FRAC_BITS-1:0]   f2, f3;
    logic [2*FRAC_BITS-1:0] sq_full, cube_full;
    logic signed [29:0]     lin;
    logic signed [54:0]     inp_full, w_full;
    logic [FRAC_BITS-1:0]   sq3, cube4;
    logic signed [29:0]     in3, inner4;

    assign f2 = (c == 0) ? sd2.fx : (c == 1) ? sd2.fh : sd2.fz;
    assign f3 = (c == 0) ? sd3.fx : (c == 1) ? sd3.fh : sd3.fz;

    assign sq_full   = {{FRAC_BITS{1'b0}}, f2} * {{FRAC_BITS{1'b0}}, f2};
    assign lin       = 30'sd6 * $signed({6'b0, f2}) - FIFTEEN_ONE;
    assign inp_full  = $signed({1'b0, f2}) * lin;
    assign cube_full = {{FRAC_BITS{1'b0}}, sq3} * {{FRAC_BITS{1'b0}}, f3};
    assign w_full    = $signed({1'b0, cube4}) * inner4;

    always_ff @(posedge clk) begin
      if (en) begin
        sq3    <= sq_full[2*FRAC_BITS-1:FRAC_BITS];
        in3    <= inp_full[FRAC_BITS+29:FRAC_BITS];
        cube4  <= cube_full[2*FRAC_BITS-1:FRAC_BITS];
        inner4 <= in3 + TEN_ONE;
        w5[c]  <= w_full[FRAC_BITS+25:FRAC_BITS];
      end
    end
  end

  // Stage 6: gradient dot products at the eight corners
  logic               v6;
  logic signed [29:0] dot6 [8];
  logic signed [25:0] w6 [3];
  logic signed [25:0] x0, x1, y0, y1, z0, z1;

  assign x0 = $signed({2'b0, sd5.fx});
  assign x1 = x0 - ONE_FIX;
  assign y0 = fy5;
  assign y1 = fy5 - ONE_FIX;
  assign z0 = $signed({2'b0, sd5.fz});
  assign z1 = z0 - ONE_FIX;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5 && sd5.typ == REQ_SAMPLE;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot6[0] <= 30'(dot_grad(hg5[0][3:0], x0, y0, z0));
      dot6[1] <= 30'(dot_grad(hg5[1][3:0], x1, y0, z0));
      dot6[2] <= 30'(dot_grad(hg5[2][3:0], x0, y1, z0));
      dot6[3] <= 30'(dot_grad(hg5[3][3:0], x1, y1, z0));
      dot6[4] <= 30'(dot_grad(hg5[4][3:0], x0, y0, z1));
      dot6[5] <= 30'(dot_grad(hg5[5][3:0], x1, y0, z1));
      dot6[6] <= 30'(dot_grad(hg5[6][3:0], x0, y1, z1));
      dot6[7] <= 30'(dot_grad(hg5[7][3:0], x1, y1, z1));
      w6      <= w5;
    end
  end

  // Stage 7: blend along x
  logic               v7;
  logic signed [29:0] l7 [4];
  logic signed [25:0] wy7, wz7;

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l7[0] <= lerp_fix(w6[0], dot6[0], dot6[1]);
      l7[1] <= lerp_fix(w6[0], dot6[2], dot6[3]);
      l7[2] <= lerp_fix(w6[0], dot6[4], dot6[5]);
      l7[3] <= lerp_fix(w6[0], dot6[6], dot6[7]);
      wy7   <= w6[1];
      wz7   <= w6[2];
    end
  end

  // Stage 8: blend along y
  logic               v8;
  logic signed [29:0] m8 [2];
  logic signed [25:0] wz8;

  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= v7;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m8[0] <= lerp_fix(wy7, l7[0], l7[1]);
      m8[1] <= lerp_fix(wy7, l7[2], l7[3]);
      wz8   <= wz7;
    end
  end

  // Output stage: blend along z and saturate
  logic signed [29:0] r9;
  assign r9 = lerp_fix(wz8, m8[0], m8[1]);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v8;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (r9 > OUT_MAX) noise_value <= OUT_MAX[25:0];
      else if (r9 < OUT_MIN)     noise_value <= OUT_MIN[25:0];
      else                       noise_value <= r9[25:0];
    end
  end

endmodule

### sv/pns_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pns_checker
// Port-level checks of the noise sample unit, bound to the top level.
// ----------------------------------------------------------------------------
module pns_checker import pns_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [25:0]  noise_value
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(noise_value))
    else $error("result changed while stalled");

  // Accept requests whenever the output register is free
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // Stall the input while a result waits
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted during output stall");

  // Drop all results after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind perlin_noise_sample_unit pns_checker u_pns_checker (.*);
